// ===== sv/koc_pkg.sv =====
// ----------------------------------------------------------------------------
// koc_pkg
// Shared types and constants for the kernel occupancy check unit.
// ----------------------------------------------------------------------------
package koc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SIZE    = 3'd0,
    REG_VREGS_SIMD   = 3'd1,
    REG_SREGS_SIMD   = 3'd2,
    REG_MAX_WAVES    = 3'd3,
    REG_SIMDS_CU     = 3'd4,
    REG_SHARED_CU    = 3'd5,
    REG_MIN_CU_COUNT = 3'd6
  } cfg_reg_t;

  // Divider latency in register stages
  localparam int DIV_LAT = 3;

  // Sideband carried alongside the first divider level
  typedef struct packed {
    logic [31:0] grid;
    logic        gsync;
    logic        complete;
    logic        vzero;
    logic        szero;
    logic        nzero;
  } l1_side_t;

  // Sideband carried alongside the second divider level
  typedef struct packed {
    logic [18:0] lds;
    logic        nzero;
    logic [31:0] grid;
    logic        gsync;
    logic        complete;
  } l2_side_t;

endpackage

// ===== sv/koc_div.sv =====
// ----------------------------------------------------------------------------
// koc_div
// Pipelined restoring divider; quotient bits split over LAT stages (last
// may get fewer), plus a sideband vector traveling with each operand pair.
// ----------------------------------------------------------------------------
module koc_div #(
  parameter int NW  = 8,
  parameter int DW  = 8,
  parameter int LAT = 3,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int SPS = (NW + LAT - 1) / LAT;  // quotient bits per stage

  logic [NW-1:0] acc_q  [LAT];
  logic [DW-1:0] rem_q  [LAT];
  logic [DW-1:0] den_q  [LAT];
  logic [SW-1:0] side_q [LAT];

  for (genvar g = 0; g < LAT; g++) begin : g_stage
    logic [NW-1:0] acc_i, acc_n;
    logic [DW-1:0] rem_i, rem_n, den_i;
    logic [SW-1:0] side_i;

    if (g == 0) begin : g_first
      assign acc_i  = num;
      assign rem_i  = '0;
      assign den_i  = den;
      assign side_i = side_in;
    end else begin : g_next
      assign acc_i  = acc_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign den_i  = den_q[g-1];
      assign side_i = side_q[g-1];
    end

    always_comb begin
      logic [DW:0] trial;
      acc_n = acc_i;
      rem_n = rem_i;
      trial = '0;
      for (int k = 0; k < SPS; k++) begin
        if (g * SPS + k < NW) begin
          trial = {rem_n, acc_n[NW-1]};
          acc_n = {acc_n[NW-2:0], 1'b0};
          if (trial >= {1'b0, den_i}) begin
            rem_n    = DW'(trial - {1'b0, den_i});
            acc_n[0] = 1'b1;
          end else begin
            rem_n = trial[DW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[g]  <= acc_n;
        rem_q[g]  <= rem_n;
        den_q[g]  <= den_i;
        side_q[g] <= side_i;
      end
    end
  end

  assign quo      = acc_q[LAT-1];
  assign side_out = side_q[LAT-1];

endmodule

// ===== sv/kernel_occupancy_check_unit.sv =====
// ----------------------------------------------------------------------------
// kernel_occupancy_check_unit
// Per-kernel occupancy and grid residency check against device limits.
// ----------------------------------------------------------------------------
// Takes one kernel descriptor per transaction and returns one result
// transaction for it. Descriptors are independent, so a new one is accepted
// every cycle in which desc_stall is low. The pipeline is built from two
// chained 3-stage restoring dividers: the first level computes
// waves per block, the register-limited wave counts and the shared-memory
// block limit; the second divides the per-CU wave budget by waves per block.
// Residency (grid / blocks <= min_cu_count) is evaluated without a divider as
// grid < (min_cu_count + 1) * blocks. The whole pipeline advances together;
// it freezes only while a result sits in the output register and res_stall is
// high, so desc_stall mirrors that condition. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and must only change while idle;
// indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module kernel_occupancy_check_unit
  import koc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // descriptor channel
  input  logic                  desc_valid,
  output logic                  desc_stall,
  input  logic [18:0]           shared_bytes_needed,
  input  logic [31:0]           grid_blocks,
  input  logic [10:0]           block_threads,
  input  logic [10:0]           vector_regs_used,
  input  logic [10:0]           scalar_regs_used,
  input  logic                  needs_global_sync,
  input  logic                  metadata_complete,
  // result channel
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [8:0]            cu_blocks,
  output logic                  annotated,
  output logic                  all_resident,
  output logic                  check_failed
);

  localparam int NSTG = 2 * DIV_LAT + 3;  // total register stages

  // Configuration registers
  logic [6:0]  wave_size;
  logic [12:0] vector_regs_per_simd;
  logic [12:0] scalar_regs_per_simd;
  logic [5:0]  max_waves_per_simd;
  logic [3:0]  simds_per_cu;
  logic [18:0] shared_bytes_per_cu;
  logic [10:0] min_cu_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_size            <= 7'd64;
      vector_regs_per_simd <= 13'd512;
      scalar_regs_per_simd <= 13'd800;
      max_waves_per_simd   <= 6'd8;
      simds_per_cu         <= 4'd4;
      shared_bytes_per_cu  <= 19'd65536;
      min_cu_count         <= 11'd64;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WAVE_SIZE:    wave_size            <= cfg_data[6:0];
        REG_VREGS_SIMD:   vector_regs_per_simd <= cfg_data[12:0];
        REG_SREGS_SIMD:   scalar_regs_per_simd <= cfg_data[12:0];
        REG_MAX_WAVES:    max_waves_per_simd   <= cfg_data[5:0];
        REG_SIMDS_CU:     simds_per_cu         <= cfg_data[3:0];
        REG_SHARED_CU:    shared_bytes_per_cu  <= cfg_data;
        REG_MIN_CU_COUNT: min_cu_count         <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a held result is stalled
  logic en;
  logic [NSTG-1:0] vld;

  assign en         = !(vld[NSTG-1] && res_stall);
  assign desc_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], desc_valid};
    end
  end

  // ---------------- first divider level ----------------
  logic [6:0]  ws_eff;
  logic [11:0] wb_num;
  l1_side_t    s1_in, s1_out;
  logic [11:0] wb_q;
  logic [12:0] qv, qs;
  logic [18:0] lds_q;
  logic [$bits(l1_side_t)-1:0] s1_vec;

  assign ws_eff = (wave_size == 7'd0) ? 7'd1 : wave_size;
  assign wb_num = 12'(block_threads) + 12'(ws_eff) - 12'd1;

  assign s1_in.grid     = grid_blocks;
  assign s1_in.gsync    = needs_global_sync;
  assign s1_in.complete = metadata_complete;
  assign s1_in.vzero    = (vector_regs_used == 11'd0);
  assign s1_in.szero    = (scalar_regs_used == 11'd0);
  assign s1_in.nzero    = (shared_bytes_needed == 19'd0);

  koc_div #(.NW(12), .DW(7), .LAT(DIV_LAT), .SW(1)) u_div_wb (
    .clk(clk), .en(en), .num(wb_num), .den(ws_eff), .side_in(1'b0),
    .quo(wb_q), .side_out()
  );

  koc_div #(.NW(13), .DW(11), .LAT(DIV_LAT), .SW(1)) u_div_v (
    .clk(clk), .en(en), .num(vector_regs_per_simd), .den(vector_regs_used),
    .side_in(1'b0), .quo(qv), .side_out()
  );

  koc_div #(.NW(13), .DW(11), .LAT(DIV_LAT), .SW(1)) u_div_s (
    .clk(clk), .en(en), .num(scalar_regs_per_simd), .den(scalar_regs_used),
    .side_in(1'b0), .quo(qs), .side_out()
  );

  koc_div #(.NW(19), .DW(19), .LAT(DIV_LAT), .SW($bits(l1_side_t))) u_div_l (
    .clk(clk), .en(en), .num(shared_bytes_per_cu), .den(shared_bytes_needed),
    .side_in(s1_in), .quo(lds_q), .side_out(s1_vec)
  );

  assign s1_out = l1_side_t'(s1_vec);

  // ---------------- wave budget stage ----------------
  logic [5:0]  wv_lim, ws_lim, waves_simd;
  logic [9:0]  budget;
  logic [11:0] wb_eff;
  logic [9:0]  m_budget;
  logic [11:0] m_wb;
  l2_side_t    m_side;

  always_comb begin
    wv_lim = max_waves_per_simd;
    if (!s1_out.vzero && (qv < {7'd0, max_waves_per_simd})) begin
      wv_lim = qv[5:0];
    end
    ws_lim = wv_lim;
    if (!s1_out.szero && (qs < {7'd0, wv_lim})) begin
      ws_lim = qs[5:0];
    end
    waves_simd = ws_lim;
    budget     = 10'(waves_simd) * 10'(simds_per_cu);
    wb_eff     = (wb_q == 12'd0) ? 12'd1 : wb_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_budget        <= budget;
      m_wb            <= wb_eff;
      m_side.lds      <= lds_q;
      m_side.nzero    <= s1_out.nzero;
      m_side.grid     <= s1_out.grid;
      m_side.gsync    <= s1_out.gsync;
      m_side.complete <= s1_out.complete;
    end
  end

  // ---------------- second divider level ----------------
  logic [9:0] gpr_q;
  logic [$bits(l2_side_t)-1:0] s2_vec;
  l2_side_t s2_out;

  koc_div #(.NW(10), .DW(12), .LAT(DIV_LAT), .SW($bits(l2_side_t))) u_div_gpr (
    .clk(clk), .en(en), .num(m_budget), .den(m_wb),
    .side_in(m_side), .quo(gpr_q), .side_out(s2_vec)
  );

  assign s2_out = l2_side_t'(s2_vec);

  // ---------------- block count stage ----------------
  logic [9:0]  b_blocks;
  logic [31:0] b_grid;
  logic        b_gsync, b_complete;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_out.nzero || ({9'd0, gpr_q} <= s2_out.lds)) begin
        b_blocks <= gpr_q;
      end else begin
        b_blocks <= s2_out.lds[9:0];
      end
      b_grid     <= s2_out.grid;
      b_gsync    <= s2_out.gsync;
      b_complete <= s2_out.complete;
    end
  end

  // ---------------- residency and output register ----------------
  logic [21:0] cu_cap;
  logic        resident, fits;

  assign cu_cap   = (22'(min_cu_count) + 22'd1) * 22'(b_blocks);
  assign resident = ({10'd0, cu_cap} > b_grid);
  assign fits     = b_complete && (b_blocks != 10'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fits) begin
        cu_blocks    <= (b_blocks > 10'd511) ? 9'd511 : b_blocks[8:0];
        annotated    <= 1'b1;
        all_resident <= resident;
        check_failed <= b_gsync && !resident;
      end else begin
        cu_blocks    <= 9'd0;
        annotated    <= 1'b0;
        all_resident <= 1'b0;
        check_failed <= b_gsync;
      end
    end
  end

  assign res_valid = vld[NSTG-1];

`ifndef SYNTHESIS
  a_ann_nonzero : assert property (@(posedge clk) disable iff (rst)
    res_valid && annotated |-> cu_blocks != 9'd0)
    else $error("annotated result with zero block count");

  a_fail_not_res : assert property (@(posedge clk) disable iff (rst)
    res_valid && check_failed |-> !all_resident)
    else $error("check failed on a resident grid");

  a_unann_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && !annotated |-> !all_resident && cu_blocks == 9'd0)
    else $error("unannotated result carries occupancy data");
`endif

endmodule
